// File: rtl/thmr_pkg.sv
// Shared constants, codes and interface types of the top-view height map raster.
package thmr_pkg;

  localparam int MAX_CELLS_PER_SIDE = 64;
  localparam int CELL_W  = $clog2(MAX_CELLS_PER_SIDE);
  localparam int ADDR_W  = 2 * CELL_W;
  localparam int GRID_W  = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int PIX_W   = 6;
  localparam int CMP_W   = (GRID_W > PIX_W) ? GRID_W : PIX_W;
  localparam int COORD_W = 32;
  localparam int EXT_W   = 31;
  localparam int GRID_REG_W = 7;
  localparam int COLOR_W = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [COORD_W-1:0] RESET_HEIGHT = COORD_W'(100 * 65536);

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SCALE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_CELLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LIMIT = 3'd4;

  typedef struct packed {
    logic        [EXT_W-1:0]   half_extent;
    logic        [EXT_W-1:0]   cell_scale;
    logic        [GRID_W-1:0]  grid;
    logic signed [COORD_W-1:0] top_limit;
    logic signed [COORD_W-1:0] bottom_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] height;
    logic        [COLOR_W-1:0] color;
  } cell_t;

  typedef struct packed {
    logic cap;
    logic mul;
    logic rd;
    logic fin;
    logic clr_wr;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       sweep_last;
    logic       out_free;
  } status_t;

endpackage

// File: rtl/top_view_height_map_raster_unit.sv
// Top level of the top-view height map raster.
//
// Input channel (in_*): one request per handshake, accepted when in_valid is
// high and in_stall is low. op selects insert point, read pixel or clear map.
// Result channel (out_*): exactly one result per request, taken when out_valid
// is high and out_stall is low. A result waits in the output register while
// the next request is accepted and processed.
// Configuration (cfg_*): cfg_index selects the register, cfg_data the value;
// cfg_ready is always high. Write only while no request is in flight.
// Insert, read and unused op pass through the states MUL, ADDR and FIN after
// accept; no new request is taken until the last one has left FIN, limited by
// the single-port cell memory read-compare-write sequence. A clear op sweeps all
// 4096 cells one per cycle in CLR and then returns its result through FIN.
// Reset: registers return to defaults and the map's 4096 cells are swept to
// their reset content, during which in_stall stays high.
// When out_stall holds a result, the block takes the next request as far as
// FIN and holds in_stall there until the output register frees.
module top_view_height_map_raster_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_op,
  input  logic signed [thmr_pkg::COORD_W-1:0]  in_pos_x,
  input  logic signed [thmr_pkg::COORD_W-1:0]  in_pos_y,
  input  logic signed [thmr_pkg::COORD_W-1:0]  in_pos_z,
  input  logic [7:0]                           in_red_in,
  input  logic [7:0]                           in_green_in,
  input  logic [7:0]                           in_blue_in,
  input  logic [thmr_pkg::PIX_W-1:0]           in_pixel_col,
  input  logic [thmr_pkg::PIX_W-1:0]           in_pixel_row,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_point_stored,
  output logic [7:0]                           out_red_out,
  output logic [7:0]                           out_green_out,
  output logic [7:0]                           out_blue_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [thmr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data
);

  thmr_pkg::cfg_t    cfg;
  thmr_pkg::cmd_t    cmd;
  thmr_pkg::status_t status;

  thmr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  thmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  thmr_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_op            (in_op),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .in_pixel_col     (in_pixel_col),
    .in_pixel_row     (in_pixel_row),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_stored (out_point_stored),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out)
  );

endmodule

// File: rtl/thmr_cfg_regs.sv
// Configuration register file and effective grid size.
module thmr_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [thmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                     cfg_data,
  output thmr_pkg::cfg_t                  cfg
);

  logic        [thmr_pkg::EXT_W-1:0]      half_extent_r;
  logic        [thmr_pkg::EXT_W-1:0]      cell_scale_r;
  logic        [thmr_pkg::GRID_REG_W-1:0] grid_cells_r;
  logic signed [thmr_pkg::COORD_W-1:0]    top_limit_r;
  logic signed [thmr_pkg::COORD_W-1:0]    bottom_limit_r;
  logic        [thmr_pkg::GRID_W-1:0]     grid_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_extent_r  <= thmr_pkg::EXT_W'(327680);
      cell_scale_r   <= thmr_pkg::EXT_W'(419430);
      grid_cells_r   <= thmr_pkg::GRID_REG_W'(64);
      top_limit_r    <= -thmr_pkg::COORD_W'(131072);
      bottom_limit_r <= thmr_pkg::COORD_W'(6553600);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        thmr_pkg::REG_HALF_EXTENT:  half_extent_r  <= cfg_data[thmr_pkg::EXT_W-1:0];
        thmr_pkg::REG_CELL_SCALE:   cell_scale_r   <= cfg_data[thmr_pkg::EXT_W-1:0];
        thmr_pkg::REG_GRID_CELLS:   grid_cells_r   <= cfg_data[thmr_pkg::GRID_REG_W-1:0];
        thmr_pkg::REG_TOP_LIMIT:    top_limit_r    <= $signed(cfg_data);
        thmr_pkg::REG_BOTTOM_LIMIT: bottom_limit_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // clamp grid size to 1..MAX_CELLS_PER_SIDE
  always_comb begin
    if (grid_cells_r == '0) begin
      grid_eff = thmr_pkg::GRID_W'(1);
    end else if (32'(grid_cells_r) > 32'(thmr_pkg::MAX_CELLS_PER_SIDE)) begin
      grid_eff = thmr_pkg::GRID_W'(thmr_pkg::MAX_CELLS_PER_SIDE);
    end else begin
      grid_eff = thmr_pkg::GRID_W'(grid_cells_r);
    end
  end

  assign cfg.half_extent  = half_extent_r;
  assign cfg.cell_scale   = cell_scale_r;
  assign cfg.grid         = grid_eff;
  assign cfg.top_limit    = top_limit_r;
  assign cfg.bottom_limit = bottom_limit_r;

endmodule

// File: rtl/thmr_ctrl.sv
// Request sequencer: capture, index, cell access, result and map clear sweep.
module thmr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  thmr_pkg::status_t status,
  output thmr_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_FIN,
    ST_CLR
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.cap    = (state_r == ST_IDLE) && in_valid;
    cmd.mul    = (state_r == ST_MUL);
    cmd.rd     = (state_r == ST_ADDR);
    cmd.fin    = (state_r == ST_FIN) && status.out_free;
    cmd.clr_wr = (state_r == ST_INIT) || (state_r == ST_CLR);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: if (status.sweep_last) state_nxt = ST_IDLE;
      ST_IDLE: if (in_valid) state_nxt = ST_MUL;
      ST_MUL: begin
        state_nxt = (status.op == thmr_pkg::OP_CLEAR) ? ST_CLR : ST_ADDR;
      end
      ST_ADDR: state_nxt = ST_FIN;
      ST_FIN:  if (status.out_free) state_nxt = ST_IDLE;
      ST_CLR:  if (status.sweep_last) state_nxt = ST_FIN;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one in flight");

endmodule

// File: rtl/thmr_datapath.sv
// Bounds check, cell index multipliers, cell memory and result register.
module thmr_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  thmr_pkg::cfg_t                     cfg,
  input  thmr_pkg::cmd_t                     cmd,
  output thmr_pkg::status_t                  status,
  input  logic [1:0]                         in_op,
  input  logic signed [thmr_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [thmr_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [thmr_pkg::COORD_W-1:0] in_pos_z,
  input  logic [7:0]                         in_red_in,
  input  logic [7:0]                         in_green_in,
  input  logic [7:0]                         in_blue_in,
  input  logic [thmr_pkg::PIX_W-1:0]         in_pixel_col,
  input  logic [thmr_pkg::PIX_W-1:0]         in_pixel_row,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_point_stored,
  output logic [7:0]                         out_red_out,
  output logic [7:0]                         out_green_out,
  output logic [7:0]                         out_blue_out
);

  localparam int NCELLS = 1 << thmr_pkg::ADDR_W;

  thmr_pkg::cell_t mem [NCELLS];

  logic [1:0]                          op_r;
  logic signed [thmr_pkg::COORD_W-1:0] x_r;
  logic signed [thmr_pkg::COORD_W-1:0] y_r;
  logic signed [thmr_pkg::COORD_W-1:0] z_r;
  logic [thmr_pkg::COLOR_W-1:0]        rgb_r;
  logic [thmr_pkg::PIX_W-1:0]          col_r;
  logic [thmr_pkg::PIX_W-1:0]          row_r;

  logic [thmr_pkg::EXT_W-1:0]          idx_x_r;
  logic [thmr_pkg::EXT_W-1:0]          idx_z_r;
  logic                                keep_r;

  logic [thmr_pkg::ADDR_W-1:0]         addr_r;
  logic                                hit_r;
  thmr_pkg::cell_t                     rd_cell_r;

  logic [thmr_pkg::ADDR_W-1:0]         clr_cnt_r;

  logic                                out_valid_r;
  logic                                point_stored_r;
  logic [thmr_pkg::COLOR_W-1:0]        color_out_r;

  logic signed [thmr_pkg::COORD_W:0]   sx;
  logic signed [thmr_pkg::COORD_W:0]   sz;
  logic signed [thmr_pkg::COORD_W:0]   hs;
  logic signed [thmr_pkg::COORD_W:0]   nhs;
  logic [thmr_pkg::COORD_W:0]          off_x;
  logic [thmr_pkg::COORD_W:0]          off_z;
  logic [63:0]                         prod_x;
  logic [63:0]                         prod_z;
  logic                                in_box;

  logic [thmr_pkg::GRID_W-1:0]         gm1;
  logic [thmr_pkg::CELL_W-1:0]         u_ins;
  logic [thmr_pkg::CELL_W-1:0]         v_ins;
  logic [thmr_pkg::CMP_W-1:0]          col_w;
  logic [thmr_pkg::CMP_W-1:0]          row_w;
  logic [thmr_pkg::CMP_W-1:0]          g_w;
  logic [thmr_pkg::CMP_W-1:0]          v_rd;
  logic                                rd_ok;
  logic [thmr_pkg::ADDR_W-1:0]         addr_nxt;
  logic                                do_store;
  logic                                out_free;

  // capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_op;
      x_r   <= in_pos_x;
      y_r   <= in_pos_y;
      z_r   <= in_pos_z;
      rgb_r <= {in_red_in, in_green_in, in_blue_in};
      col_r <= in_pixel_col;
      row_r <= in_pixel_row;
    end
  end

  // bounds and cell index products
  assign sx  = $signed({x_r[thmr_pkg::COORD_W-1], x_r});
  assign sz  = $signed({z_r[thmr_pkg::COORD_W-1], z_r});
  assign hs  = $signed({2'b00, cfg.half_extent});
  assign nhs = -hs;
  assign off_x = {x_r[thmr_pkg::COORD_W-1], x_r} + {2'b00, cfg.half_extent};
  assign off_z = {z_r[thmr_pkg::COORD_W-1], z_r} + {2'b00, cfg.half_extent};
  assign prod_x = 64'(off_x) * 64'(cfg.cell_scale);
  assign prod_z = 64'(off_z) * 64'(cfg.cell_scale);
  assign in_box = (sx >= nhs) && (sx <= hs) && (sz >= nhs) && (sz <= hs) &&
                  (y_r >= cfg.top_limit) && (y_r <= cfg.bottom_limit);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      idx_x_r <= prod_x[62:32];
      idx_z_r <= prod_z[62:32];
      keep_r  <= in_box;
    end
  end

  // cell address
  assign gm1 = cfg.grid - thmr_pkg::GRID_W'(1);
  assign u_ins = (idx_x_r > thmr_pkg::EXT_W'(gm1)) ? thmr_pkg::CELL_W'(gm1)
                                                   : idx_x_r[thmr_pkg::CELL_W-1:0];
  assign v_ins = (idx_z_r > thmr_pkg::EXT_W'(gm1)) ? thmr_pkg::CELL_W'(gm1)
                                                   : idx_z_r[thmr_pkg::CELL_W-1:0];
  assign col_w = thmr_pkg::CMP_W'(col_r);
  assign row_w = thmr_pkg::CMP_W'(row_r);
  assign g_w   = thmr_pkg::CMP_W'(cfg.grid);
  assign rd_ok = (col_w < g_w) && (row_w < g_w);
  assign v_rd  = g_w - thmr_pkg::CMP_W'(1) - row_w;

  always_comb begin
    if (op_r == thmr_pkg::OP_READ) begin
      addr_nxt = {thmr_pkg::CELL_W'(col_w), thmr_pkg::CELL_W'(v_rd)};
    end else begin
      addr_nxt = {u_ins, v_ins};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      addr_r    <= addr_nxt;
      hit_r     <= rd_ok;
      rd_cell_r <= mem[addr_nxt];
    end
  end

  assign do_store = (op_r == thmr_pkg::OP_INSERT) && keep_r &&
                    (y_r < rd_cell_r.height);

  // memory write: clear sweep or insert update
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_cnt_r] <= '{height: thmr_pkg::RESET_HEIGHT, color: '0};
    end else if (cmd.fin && do_store) begin
      mem[addr_r] <= '{height: y_r, color: rgb_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= clr_cnt_r + thmr_pkg::ADDR_W'(1);
    end
  end

  // result register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      point_stored_r <= do_store;
      color_out_r    <= (op_r == thmr_pkg::OP_READ && hit_r) ? rd_cell_r.color : '0;
    end
  end

  assign status.op         = op_r;
  assign status.sweep_last = (clr_cnt_r == {thmr_pkg::ADDR_W{1'b1}});
  assign status.out_free   = out_free;

  assign out_valid        = out_valid_r;
  assign out_point_stored = point_stored_r;
  assign out_red_out      = color_out_r[23:16];
  assign out_green_out    = color_out_r[15:8];
  assign out_blue_out     = color_out_r[7:0];

  a_fin_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> out_free)
    else $error("result loaded over a waiting result");

  a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && (cmd.fin || cmd.rd)))
    else $error("clear sweep overlaps a cell access");

  a_store_no_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && point_stored_r) |->
      (out_red_out == 8'd0 && out_green_out == 8'd0 && out_blue_out == 8'd0))
    else $error("insert result carries color");

endmodule
